>>> rtl/beq_pkg.sv
// Shared constants, codes, command struct and saturation helpers for the
// cascaded biquad equalizer. No dependencies; used by every rtl file.
package beq_pkg;

    // Fixed field widths and sizes
    localparam int CHANNELS       = 8;
    localparam int BANDS          = 3;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 27;
    localparam int COEF_BITS      = 32;
    localparam int DELAY_BITS     = 40;
    localparam int CHAN_BITS      = 3;
    localparam int CMD_BITS       = 2;
    localparam int CIDX_FIELD_BITS = 4;

    // Coefficients per band: b0, b1, b2, a1, a2
    localparam int NPOS      = 5;
    localparam int NCOEF     = BANDS * NPOS;
    localparam int CIDX_BITS = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int ROWS      = CHANNELS * BANDS;
    localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BAND_BITS = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int POS_BITS  = 3;

    // Datapath widths
    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int RND_BITS  = PROD_BITS - COEF_FRAC_BITS;
    localparam int ACC_BITS  = DELAY_BITS + 2;

    // Stream packing
    localparam int S_TDATA_BITS =
        ((SAMPLE_BITS + CIDX_FIELD_BITS + COEF_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = CMD_BITS + CHAN_BITS;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = CHAN_BITS;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_PROC  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_COEF  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    // Coefficient positions within a band
    localparam logic [POS_BITS-1:0] POS_B0 = 3'd0;
    localparam logic [POS_BITS-1:0] POS_B1 = 3'd1;
    localparam logic [POS_BITS-1:0] POS_B2 = 3'd2;
    localparam logic [POS_BITS-1:0] POS_A1 = 3'd3;
    localparam logic [POS_BITS-1:0] POS_A2 = 3'd4;

    // Datapath step codes: what to do with the product in flight
    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] STEP_NONE = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_Y    = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_ACC1 = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_N1   = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_ACC2 = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_N2   = 3'd5;

    typedef struct packed {
        logic                  load;
        logic                  coef_wr;
        logic                  clear;
        logic                  mul_en;
        logic [POS_BITS-1:0]   pos;
        logic                  mul_y;
        logic [BAND_BITS-1:0]  band;
        logic                  rd_en;
        logic [STEP_BITS-1:0]  step;
        logic [BAND_BITS-1:0]  wr_band;
        logic                  out_load;
    } beq_cmd_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-SAMPLE_BITS:0] top;
        top = v[ACC_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            return v[SAMPLE_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [DELAY_BITS-1:0] sat_delay(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-DELAY_BITS:0] top;
        top = v[ACC_BITS-1:DELAY_BITS-1];
        if ((&top) || !(|top))
            return v[DELAY_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(DELAY_BITS-1){1'b0}}};
        else
            return {1'b0, {(DELAY_BITS-1){1'b1}}};
    endfunction

endpackage

>>> rtl/beq_ctrl.sv
// Sequencer for the equalizer: accepts items and steps the shared
// multiplier through five products per band. Depends on beq_pkg.
module beq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [beq_pkg::CMD_BITS-1:0]     cmd,
    input  logic [beq_pkg::CHAN_BITS-1:0]    channel,
    input  logic                             out_free,
    output beq_pkg::beq_cmd_t                ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_B1    = 3'd2;
    localparam logic [2:0] S_A1    = 3'd3;
    localparam logic [2:0] S_B2    = 3'd4;
    localparam logic [2:0] S_A2    = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;
    localparam logic [2:0] S_PUT   = 3'd7;

    localparam logic [beq_pkg::BAND_BITS-1:0] LAST_BAND =
        beq_pkg::BAND_BITS'(beq_pkg::BANDS - 1);

    logic [2:0]                      state_reg, state_next;
    logic [beq_pkg::BAND_BITS-1:0]   band_reg, band_next;
    logic                            chan_ok;

    assign chan_ok  = (int'(channel) < beq_pkg::CHANNELS);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        band_next   = band_reg;
        ctl         = '0;
        ctl.band    = band_reg;
        ctl.wr_band = band_reg;
        ctl.step    = beq_pkg::STEP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        beq_pkg::CMD_PROC:
                        begin
                            if (chan_ok)
                            begin
                                ctl.load   = 1'b1;
                                band_next  = '0;
                                state_next = S_FIRST;
                            end
                        end
                        beq_pkg::CMD_COEF:  ctl.coef_wr = 1'b1;
                        beq_pkg::CMD_CLEAR: ctl.clear   = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_FIRST:
            begin
                ctl.mul_en = 1'b1;
                ctl.pos    = beq_pkg::POS_B0;
                ctl.rd_en  = 1'b1;
                state_next = S_B1;
            end
            S_B1:
            begin
                ctl.step   = beq_pkg::STEP_Y;
                ctl.mul_en = 1'b1;
                ctl.pos    = beq_pkg::POS_B1;
                state_next = S_A1;
            end
            S_A1:
            begin
                ctl.step   = beq_pkg::STEP_ACC1;
                ctl.mul_en = 1'b1;
                ctl.pos    = beq_pkg::POS_A1;
                ctl.mul_y  = 1'b1;
                state_next = S_B2;
            end
            S_B2:
            begin
                ctl.step   = beq_pkg::STEP_N1;
                ctl.mul_en = 1'b1;
                ctl.pos    = beq_pkg::POS_B2;
                state_next = S_A2;
            end
            S_A2:
            begin
                ctl.step   = beq_pkg::STEP_ACC2;
                ctl.mul_en = 1'b1;
                ctl.pos    = beq_pkg::POS_A2;
                ctl.mul_y  = 1'b1;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                ctl.step = beq_pkg::STEP_N2;
                if (band_reg != LAST_BAND)
                begin
                    // start the next band on this band's output
                    ctl.band   = band_reg + 1'b1;
                    ctl.mul_en = 1'b1;
                    ctl.pos    = beq_pkg::POS_B0;
                    ctl.mul_y  = 1'b1;
                    ctl.rd_en  = 1'b1;
                    band_next  = band_reg + 1'b1;
                    state_next = S_B1;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            band_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            band_reg  <= band_next;
        end
    end

endmodule

>>> rtl/beq_datapath.sv
// Equalizer datapath: coefficient store, delay memory, shared multiplier,
// rounding, accumulation, saturation and output register. Depends on beq_pkg.
module beq_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  beq_pkg::beq_cmd_t                     ctl,
    input  logic [beq_pkg::CHAN_BITS-1:0]         channel,
    input  logic signed [beq_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic [beq_pkg::CIDX_FIELD_BITS-1:0]   coef_index,
    input  logic signed [beq_pkg::COEF_BITS-1:0]  coef_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_free,
    output logic [beq_pkg::CHAN_BITS-1:0]         channel_out,
    output logic signed [beq_pkg::SAMPLE_BITS-1:0] sample_out
);

    localparam logic signed [beq_pkg::COEF_BITS-1:0] COEF_ONE =
        beq_pkg::COEF_BITS'(64'sd1 <<< beq_pkg::COEF_FRAC_BITS);
    localparam logic signed [beq_pkg::PROD_BITS-1:0] RND_BIAS =
        beq_pkg::PROD_BITS'(64'sd1 <<< (beq_pkg::COEF_FRAC_BITS - 1));

    // Coefficient store
    logic signed [beq_pkg::COEF_BITS-1:0] coef_reg [beq_pkg::NCOEF];
    logic [beq_pkg::CIDX_BITS-1:0]        coef_addr;
    logic signed [beq_pkg::COEF_BITS-1:0] coef_sel;

    // Delay memory, one row of {z2, z1} per channel and band
    logic [2*beq_pkg::DELAY_BITS-1:0]     mem [beq_pkg::ROWS];
    logic [beq_pkg::ROWS-1:0]             row_valid_reg;
    logic [2*beq_pkg::DELAY_BITS-1:0]     rd_data_reg;
    logic                                 rd_valid_reg;
    logic [beq_pkg::ROW_BITS-1:0]         rd_row, wr_row;
    logic signed [beq_pkg::DELAY_BITS-1:0] z1, z2;

    // Arithmetic
    logic [beq_pkg::CHAN_BITS-1:0]        ch_reg;
    logic signed [beq_pkg::SAMPLE_BITS-1:0] x_reg, y_reg, y_next, opnd;
    logic signed [beq_pkg::PROD_BITS-1:0] prod_reg, rnd_sum;
    logic signed [beq_pkg::RND_BITS-1:0]  r;
    logic signed [beq_pkg::ACC_BITS-1:0]  r_ext, acc_reg, sum_y, sum_n;
    logic signed [beq_pkg::DELAY_BITS-1:0] n1_reg, n_sat;

    // Output register
    logic                                 out_valid_reg;
    logic [beq_pkg::CHAN_BITS-1:0]        ch_out_reg;
    logic signed [beq_pkg::SAMPLE_BITS-1:0] smp_out_reg;

    assign coef_addr = beq_pkg::CIDX_BITS'(int'(ctl.band) * beq_pkg::NPOS + int'(ctl.pos));
    assign coef_sel  = coef_reg[coef_addr];
    assign opnd      = ctl.mul_y ? y_reg : x_reg;

    assign rd_row = beq_pkg::ROW_BITS'(int'(ch_reg) * beq_pkg::BANDS + int'(ctl.band));
    assign wr_row = beq_pkg::ROW_BITS'(int'(ch_reg) * beq_pkg::BANDS + int'(ctl.wr_band));
    assign z1 = rd_valid_reg ? $signed(rd_data_reg[beq_pkg::DELAY_BITS-1:0]) : '0;
    assign z2 = rd_valid_reg ?
        $signed(rd_data_reg[2*beq_pkg::DELAY_BITS-1:beq_pkg::DELAY_BITS]) : '0;

    // round half up, then arithmetic shift by the fraction width
    assign rnd_sum = prod_reg + RND_BIAS;
    assign r       = $signed(rnd_sum[beq_pkg::PROD_BITS-1:beq_pkg::COEF_FRAC_BITS]);
    assign r_ext   = beq_pkg::ACC_BITS'(r);
    assign sum_y   = r_ext + beq_pkg::ACC_BITS'(z1);
    assign y_next  = beq_pkg::sat_sample(sum_y);
    assign sum_n   = acc_reg - r_ext;
    assign n_sat   = beq_pkg::sat_delay(sum_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < beq_pkg::BANDS; b++)
            begin
                for (int p = 0; p < beq_pkg::NPOS; p++)
                begin
                    coef_reg[b*beq_pkg::NPOS + p] <= (p == 0) ? COEF_ONE : '0;
                end
            end
        end
        else if (ctl.coef_wr && (int'(coef_index) < beq_pkg::NCOEF))
        begin
            coef_reg[beq_pkg::CIDX_BITS'(coef_index)] <= coef_value;
        end
    end

    // Valid bits stand in for a cleared delay row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
                row_valid_reg <= '0;
            else if (ctl.step == beq_pkg::STEP_N2)
                row_valid_reg[wr_row] <= 1'b1;
            if (ctl.rd_en)
                rd_valid_reg <= row_valid_reg[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step == beq_pkg::STEP_N2)
            mem[wr_row] <= {n_sat, n1_reg};
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ch_reg <= channel;
            x_reg  <= sample_in;
        end
        else if (ctl.step == beq_pkg::STEP_N2)
        begin
            x_reg <= y_reg;
        end
        if (ctl.mul_en)
            prod_reg <= coef_sel * opnd;
        case (ctl.step)
            beq_pkg::STEP_Y:    y_reg   <= y_next;
            beq_pkg::STEP_ACC1: acc_reg <= r_ext + beq_pkg::ACC_BITS'(z2);
            beq_pkg::STEP_N1:   n1_reg  <= n_sat;
            beq_pkg::STEP_ACC2: acc_reg <= r_ext;
            default: ;
        endcase
        if (ctl.out_load)
        begin
            ch_out_reg  <= ch_reg;
            smp_out_reg <= y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign channel_out = ch_out_reg;
    assign sample_out  = smp_out_reg;

endmodule

>>> rtl/cascaded_biquad_equalizer.sv
// Top level of the cascaded biquad equalizer: stream ports, controller and
// datapath. Depends on beq_pkg, beq_ctrl and beq_datapath.
//
// Each transfer on the slave side carries one command. A process command
// runs the sample through all bands in series (direct form II transposed),
// using the delay words kept for its channel, and yields one filtered,
// saturated sample on the master side, tagged with its channel. A write
// command replaces one coefficient (band times five plus b0, b1, b2, a1, a2
// position); a clear command zeroes all delay words; neither gives a
// result, and code 3, a coefficient index beyond the store or a channel
// beyond the channel count is dropped without effect. After reset every
// band passes audio through unchanged (b0 = 1.0, the rest zero) and all
// delay words are zero. One multiplier serves all five products of a band,
// so the block takes no new command until a sample has passed through
// every band and been put in the output register; write and clear
// commands leave it free for the next one. A finished sample waits in an
// output register, and the block takes the next command while it waits;
// it holds the next result back until that register has been emptied.
module cascaded_biquad_equalizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_in, coef_index, coef_value, zero fill
    input  logic [beq_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // cmd, channel
    input  logic [beq_pkg::S_TUSER_BITS-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_out
    output logic [beq_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // channel_out
    output logic [beq_pkg::M_TUSER_BITS-1:0]    m_tuser
);

    localparam int CIDX_LO = beq_pkg::SAMPLE_BITS;
    localparam int COEF_LO = CIDX_LO + beq_pkg::CIDX_FIELD_BITS;

    beq_pkg::beq_cmd_t                     ctl;
    logic                                  out_free;
    logic [beq_pkg::CMD_BITS-1:0]          cmd;
    logic [beq_pkg::CHAN_BITS-1:0]         channel;
    logic signed [beq_pkg::SAMPLE_BITS-1:0] sample_in;
    logic [beq_pkg::CIDX_FIELD_BITS-1:0]   coef_index;
    logic signed [beq_pkg::COEF_BITS-1:0]  coef_value;
    logic [beq_pkg::CHAN_BITS-1:0]         channel_out;
    logic signed [beq_pkg::SAMPLE_BITS-1:0] sample_out;

    // Unpack the slave transfer
    assign cmd        = s_tuser[beq_pkg::CMD_BITS-1:0];
    assign channel    = s_tuser[beq_pkg::CMD_BITS +: beq_pkg::CHAN_BITS];
    assign sample_in  = $signed(s_tdata[beq_pkg::SAMPLE_BITS-1:0]);
    assign coef_index = s_tdata[CIDX_LO +: beq_pkg::CIDX_FIELD_BITS];
    assign coef_value = $signed(s_tdata[COEF_LO +: beq_pkg::COEF_BITS]);

    beq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .channel  (channel),
        .out_free (out_free),
        .ctl      (ctl)
    );

    beq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .channel     (channel),
        .sample_in   (sample_in),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_free    (out_free),
        .channel_out (channel_out),
        .sample_out  (sample_out)
    );

    // Pack the master transfer, zero fill above the sample
    assign m_tdata = beq_pkg::M_TDATA_BITS'($unsigned(sample_out));
    assign m_tuser = channel_out;

endmodule
